[design/look_at_rotation_macros.svh]
// Assertion macros for the look-at rotation top level.
// Expects clk and rst in the scope of the module that includes it.
`ifndef LOOK_AT_ROTATION_MACROS_SVH
`define LOOK_AT_ROTATION_MACROS_SVH

// Property checked outside reset.
`define LAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define LAR_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

[design/lar_pkg.sv]
// Package for the look-at rotation block: widths, register indexes and
// the block-scaling helpers. No dependencies.
`timescale 1ns / 1ps
package lar_pkg;

  localparam int MAG_W      = 30;  // scaled magnitude, top component in [2^29, 2^30)
  localparam int PROD_W     = 60;  // product of two scaled magnitudes
  localparam int UPY_W      = 61;  // sum of two squares
  localparam int SUM_W      = 62;  // sum of three squares
  localparam int LEN_W      = 31;  // vector length
  localparam int DIV_W      = 32;  // divisor, twice the length
  localparam int Q_W        = 15;  // quotient magnitude
  localparam int REM_W      = 46;  // dividend and remainder
  localparam int OUT_W      = 16;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 15;

  localparam logic [Q_W-1:0] ONE_Q14 = 15'd16384;

  localparam logic [1:0] CFG_POS_X = 2'd0;
  localparam logic [1:0] CFG_POS_Y = 2'd1;
  localparam logic [1:0] CFG_POS_Z = 2'd2;

  // Number of significant bits of x.
  function automatic logic [6:0] bit_len(input logic [63:0] x);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

  // Bring a magnitude to the common exponent where a bits-wide value lands in [2^29, 2^30).
  function automatic logic [MAG_W-1:0] scale30(input logic [63:0] m, input logic [6:0] bits);
    logic [63:0] s;
    if (bits > 7'd30) s = m >> (bits - 7'd30);
    else s = m << (7'd30 - bits);
    return s[MAG_W-1:0];
  endfunction

endpackage

[design/lar_front.sv]
// Front end: target minus position, block scaling and the products that
// build the up direction. Depends on lar_pkg.
`timescale 1ns / 1ps
module lar_front import lar_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [31:0]         tgt [3],
  input  logic [31:0]         pos [3],
  output logic                valid,
  output logic [MAG_W-1:0]    v_mag [3],
  output logic [2:0]          v_neg,
  output logic [PROD_W-1:0]   up_xy,
  output logic [PROD_W-1:0]   up_yz,
  output logic [UPY_W-1:0]    up_yy
);

  logic              f1_v, f2_v, f3_v, f4_v;
  logic [32:0]       d [3];
  logic [32:0]       absd [3];
  logic [32:0]       f2_mag [3];
  logic [2:0]        f2_neg;
  logic [6:0]        f2_bits;
  logic [MAG_W-1:0]  f3_mag [3];
  logic [2:0]        f3_neg;
  logic [MAG_W-1:0]  f4_mag [3];
  logic [2:0]        f4_neg;
  logic [PROD_W-1:0] pxy, pxx, pzz, pyz;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      absd[j] = d[j][32] ? 33'(-d[j]) : d[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v  <= 1'b0;
      f2_v  <= 1'b0;
      f3_v  <= 1'b0;
      f4_v  <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      f1_v  <= in_valid;
      f2_v  <= f1_v;
      f3_v  <= f2_v;
      f4_v  <= f3_v;
      valid <= f4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        d[j]      <= {tgt[j][31], tgt[j]} - {pos[j][31], pos[j]};
        f2_mag[j] <= absd[j];
        f2_neg[j] <= d[j][32];
        f3_mag[j] <= scale30(64'(f2_mag[j]), f2_bits);
        f4_mag[j] <= f3_mag[j];
        v_mag[j]  <= f4_mag[j];
      end
      f2_bits <= bit_len(64'(absd[0] | absd[1] | absd[2]));
      f3_neg  <= f2_neg;
      f4_neg  <= f3_neg;
      v_neg   <= f4_neg;
      pxy     <= PROD_W'(f3_mag[0]) * PROD_W'(f3_mag[1]);
      pxx     <= PROD_W'(f3_mag[0]) * PROD_W'(f3_mag[0]);
      pzz     <= PROD_W'(f3_mag[2]) * PROD_W'(f3_mag[2]);
      pyz     <= PROD_W'(f3_mag[1]) * PROD_W'(f3_mag[2]);
      up_xy   <= pxy;
      up_yz   <= pyz;
      up_yy   <= UPY_W'(pxx) + UPY_W'(pzz);
    end
  end

endmodule

[design/lar_norm.sv]
// Normalizer for one direction: block scaling, sum of squares, pipelined
// square root and pipelined division to Q1.14. Depends on lar_pkg.
`timescale 1ns / 1ps
module lar_norm import lar_pkg::*; #(
  parameter int W = MAG_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [W-1:0]     mag [3],
  input  logic [2:0]       neg,
  output logic             out_valid,
  output logic [OUT_W-1:0] comp [3],
  output logic             zero
);

  // scale
  logic             a_v, b_v, c_v, d_v;
  logic [W-1:0]     a_mag [3];
  logic [2:0]       a_neg, b_neg, c_neg, d_neg;
  logic [6:0]       a_bits;
  logic [MAG_W-1:0] b_mag [3], c_mag [3], d_mag [3];
  logic             b_zero, c_zero, d_zero;
  logic [PROD_W-1:0] c_sq [3];
  logic [SUM_W-1:0] d_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
    end else if (en) begin
      a_v <= in_valid;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        a_mag[j] <= mag[j];
        b_mag[j] <= scale30(64'(a_mag[j]), a_bits);
        c_mag[j] <= b_mag[j];
        c_sq[j]  <= PROD_W'(b_mag[j]) * PROD_W'(b_mag[j]);
        d_mag[j] <= c_mag[j];
      end
      a_neg  <= neg;
      a_bits <= bit_len(64'(mag[0] | mag[1] | mag[2]));
      b_neg  <= a_neg;
      b_zero <= (a_bits == 7'd0);
      c_neg  <= b_neg;
      c_zero <= b_zero;
      d_neg  <= c_neg;
      d_zero <= c_zero;
      d_n    <= SUM_W'(c_sq[0]) + SUM_W'(c_sq[1]) + SUM_W'(c_sq[2]);
    end
  end

  // square root, one result bit per stage
  logic [SUM_W-1:0] sn [SQRT_STEPS];
  logic [SUM_W:0]   sr [SQRT_STEPS+1];
  logic [MAG_W-1:0] sm [SQRT_STEPS+1][3];
  logic [2:0]       sneg [SQRT_STEPS+1];
  logic             sz [SQRT_STEPS+1];
  logic             sv [SQRT_STEPS+1];

  assign sn[0]   = d_n;
  assign sr[0]   = '0;
  assign sm[0]   = d_mag;
  assign sneg[0] = d_neg;
  assign sz[0]   = d_zero;
  assign sv[0]   = d_v;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SUM_W:0] BIT = (SUM_W+1)'(1) << (SUM_W - 2*k);
    logic [SUM_W:0] t;
    logic           ge;
    assign t  = sr[k] + BIT;
    assign ge = {1'b0, sn[k]} >= t;

    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else if (en) sv[k+1] <= sv[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sr[k+1]   <= ge ? (sr[k] >> 1) + BIT : sr[k] >> 1;
        sm[k+1]   <= sm[k];
        sneg[k+1] <= sneg[k];
        sz[k+1]   <= sz[k];
      end
    end

    if (k + 1 < SQRT_STEPS) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) sn[k+1] <= ge ? sn[k] - t[SUM_W-1:0] : sn[k];
      end
    end
  end

  // division setup: (mag * 2^15 + len) / (2 * len)
  logic [LEN_W-1:0] len;
  logic [REM_W-1:0] dr [DIV_STEPS][3];
  logic [Q_W-1:0]   dq [DIV_STEPS+1][3];
  logic [DIV_W-1:0] dd [DIV_STEPS];
  logic [2:0]       dneg [DIV_STEPS+1];
  logic             dz [DIV_STEPS+1];
  logic             dv [DIV_STEPS+1];

  assign len = sr[SQRT_STEPS][LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (en) dv[0] <= sv[SQRT_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        dr[0][j] <= REM_W'({sm[SQRT_STEPS][j], Q_W'(0)}) + REM_W'(len);
      end
      dd[0]   <= {len, 1'b0};
      dneg[0] <= sneg[SQRT_STEPS];
      dz[0]   <= sz[SQRT_STEPS];
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_q0
    assign dq[0][j] = '0;
  end

  // restoring division, one quotient bit per stage
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    localparam int SH = Q_W - 1 - s;
    logic [REM_W-1:0] trial;
    logic [2:0]       ge;
    assign trial = REM_W'(dd[s]) << SH;

    always_ff @(posedge clk) begin
      if (rst) dv[s+1] <= 1'b0;
      else if (en) dv[s+1] <= dv[s];
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
      assign ge[j] = dr[s][j] >= trial;
      always_ff @(posedge clk) begin
        if (en) dq[s+1][j] <= ge[j] ? dq[s][j] | (Q_W'(1) << SH) : dq[s][j];
      end
      if (s + 1 < DIV_STEPS) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) dr[s+1][j] <= ge[j] ? dr[s][j] - trial : dr[s][j];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dneg[s+1] <= dneg[s];
        dz[s+1]   <= dz[s];
      end
    end

    if (s + 1 < DIV_STEPS) begin : g_dsr
      always_ff @(posedge clk) begin
        if (en) dd[s+1] <= dd[s];
      end
    end
  end

  // clamp, zero the degenerate case, apply sign
  logic [Q_W-1:0] qc [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (dz[DIV_STEPS]) qc[j] = '0;
      else if (dq[DIV_STEPS][j] > ONE_Q14) qc[j] = ONE_Q14;
      else qc[j] = dq[DIV_STEPS][j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dv[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        comp[j] <= dneg[DIV_STEPS][j] ? OUT_W'(-OUT_W'(qc[j])) : OUT_W'(qc[j]);
      end
      zero <= dz[DIV_STEPS];
    end
  end

endmodule

[design/look_at_rotation.sv]
// Top level of the look-at rotation block: configuration registers,
// front end, three normalizers and the output skid stage.
// Depends on lar_pkg, lar_front, lar_norm and look_at_rotation_macros.svh.
//
//   port group   dir  payload
//   s_*          in   target_x/y/z, 32 bits each, Q16.16
//   m_*          out  right, up, fwd xyz in Q1.14; tuser = degenerate
//   cfg_*        in   index 0..2 selects pos_x/y/z, 32-bit data
//
// One item per clock sustained while no stall holds the pipeline; the square root
// has 32 stages and the divider 15 stages.
// Reset (rst, synchronous) clears all valid bits and the position to 0.
// A stall on m_tready freezes the whole pipeline once the skid stage holds
// an item; s_tready stays high for the first cycle of a stall.
`timescale 1ns / 1ps
`include "look_at_rotation_macros.svh"
module look_at_rotation import lar_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // target_x, target_y, target_z
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata,   // right_x/y/z, up_x/y/z, fwd_x/y/z
  output logic [0:0]   m_tuser,   // degenerate
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic [31:0] pos [3];
  logic [31:0] tgt [3];
  logic        en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos[0] <= '0;
      pos[1] <= '0;
      pos[2] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_POS_X: pos[0] <= cfg_data;
        CFG_POS_Y: pos[1] <= cfg_data;
        CFG_POS_Z: pos[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign tgt[0] = s_tdata[31:0];
  assign tgt[1] = s_tdata[63:32];
  assign tgt[2] = s_tdata[95:64];

  logic              skid_v;
  logic              v_valid;
  logic [MAG_W-1:0]  v_mag [3];
  logic [2:0]        v_neg;
  logic [PROD_W-1:0] up_xy, up_yz;
  logic [UPY_W-1:0]  up_yy;

  assign en       = !skid_v;
  assign s_tready = en;

  lar_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .tgt      (tgt),
    .pos      (pos),
    .valid    (v_valid),
    .v_mag    (v_mag),
    .v_neg    (v_neg),
    .up_xy    (up_xy),
    .up_yz    (up_yz),
    .up_yy    (up_yy)
  );

  // right = (v_z, 0, -v_x); up = (-v_x*v_y, v_x^2 + v_z^2, -v_y*v_z)
  logic [MAG_W-1:0] r_mag [3];
  logic [2:0]       r_neg;
  logic [UPY_W-1:0] u_mag [3];
  logic [2:0]       u_neg;

  assign r_mag[0] = v_mag[2];
  assign r_mag[1] = '0;
  assign r_mag[2] = v_mag[0];
  assign r_neg    = {~v_neg[0], 1'b0, v_neg[2]};
  assign u_mag[0] = UPY_W'(up_xy);
  assign u_mag[1] = up_yy;
  assign u_mag[2] = UPY_W'(up_yz);
  assign u_neg    = {~(v_neg[1] ^ v_neg[2]), 1'b0, ~(v_neg[0] ^ v_neg[1])};

  logic             f_v, r_v, u_v;
  logic [OUT_W-1:0] f_c [3], r_c [3], u_c [3];
  logic             f_z, r_z, u_z;

  lar_norm #(.W(MAG_W)) u_norm_fwd (
    .clk (clk), .rst (rst), .en (en), .in_valid (v_valid),
    .mag (v_mag), .neg (v_neg),
    .out_valid (f_v), .comp (f_c), .zero (f_z)
  );

  lar_norm #(.W(MAG_W)) u_norm_right (
    .clk (clk), .rst (rst), .en (en), .in_valid (v_valid),
    .mag (r_mag), .neg (r_neg),
    .out_valid (r_v), .comp (r_c), .zero (r_z)
  );

  lar_norm #(.W(UPY_W)) u_norm_up (
    .clk (clk), .rst (rst), .en (en), .in_valid (v_valid),
    .mag (u_mag), .neg (u_neg),
    .out_valid (u_v), .comp (u_c), .zero (u_z)
  );

  logic [143:0] last_d, skid_d;
  logic         last_u, skid_u;

  assign last_d = {f_c[2], f_c[1], f_c[0], u_c[2], u_c[1], u_c[0], r_c[2], r_c[1], r_c[0]};
  assign last_u = f_z | r_z | u_z;

  // output register with a one-item skid behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_v   <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= skid_v | f_v;
      skid_v   <= 1'b0;
    end else if (f_v && en) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      m_tdata    <= skid_v ? skid_d : last_d;
      m_tuser[0] <= skid_v ? skid_u : last_u;
    end else if (f_v && en) begin
      skid_d <= last_d;
      skid_u <= last_u;
    end
  end

  `LAR_ASSERT(a_lanes_aligned, (f_v == r_v) && (f_v == u_v), "normalizer lanes out of step")
  `LAR_ASSERT_IMP(a_skid_behind_out, skid_v, m_tvalid, "skid holds an item behind an empty output")
  `LAR_ASSERT_IMP(a_zero_fwd_flag, m_tvalid && (m_tdata[143:96] == '0), m_tuser[0], "zero forward without degenerate flag")

endmodule

[verif/look_at_rotation_test.sv]
// Testbench for look_at_rotation: drives targets and position writes, predicts
// each rotation with an integer model of the look-at math, and checks results.
// Depends on lar_pkg and the look_at_rotation RTL.
`timescale 1ns / 1ps
module look_at_rotation_test import lar_pkg::*;;

  typedef struct packed {
    logic [15:0] rx, ry, rz, ux, uy, uz, fx, fy, fz;
    logic        degen;
  } rot_t;

  localparam logic [1:0] CFG_UNMAPPED = 2'd3;

  logic clk, rst;
  logic s_tvalid, s_tready;
  logic [95:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [143:0] m_tdata;
  logic [0:0] m_tuser;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  look_at_rotation DUT (.*);

  logic signed [31:0] cam_x, cam_y, cam_z;
  rot_t pending_rot[$];
  int errors = 0;
  int sent = 0;
  bit idle_on = 1;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic bit gap();
    return idle_on && ($urandom_range(99) < 13);
  endfunction

  // Block scale into [2^29, 2^30); returns 0 for a zero vector.
  function automatic bit scale_vec(input longint signed a[3], output longint unsigned m[3],
                                   output bit n[3]);
    longint unsigned top;
    int nb;
    top = 0;
    nb = 0;
    for (int i = 0; i < 3; i++) begin
      n[i] = a[i] < 0;
      m[i] = n[i] ? -a[i] : a[i];
      if (m[i] > top) top = m[i];
    end
    if (top == 0) return 0;
    while (nb < 64 && (top >> nb) != 0) nb++;
    for (int i = 0; i < 3; i++)
      m[i] = (nb > 30) ? m[i] >> (nb - 30) : m[i] << (30 - nb);
    return 1;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit unit_vec(input longint signed a[3], output logic [15:0] o[3]);
    longint unsigned m[3], len, q;
    bit n[3];
    if (!scale_vec(a, m, n)) begin
      o = '{16'd0, 16'd0, 16'd0};
      return 0;
    end
    len = floor_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 15) + len) / (len << 1);
      if (q > 16384) q = 16384;
      o[i] = n[i] ? 16'(-q) : 16'(q);
    end
    return 1;
  endfunction

  function automatic rot_t look_at(input logic [31:0] tx, ty, tz);
    longint signed d[3], v[3], dr[3], du[3];
    longint unsigned m[3];
    bit n[3], okf, okr, oku;
    logic [15:0] f[3], r[3], u[3];
    rot_t res;
    d[0] = longint'($signed(tx)) - cam_x;
    d[1] = longint'($signed(ty)) - cam_y;
    d[2] = longint'($signed(tz)) - cam_z;
    if (scale_vec(d, m, n)) begin
      for (int i = 0; i < 3; i++) v[i] = n[i] ? -longint'(m[i]) : longint'(m[i]);
    end else begin
      v = '{0, 0, 0};
    end
    dr = '{v[2], 0, -v[0]};
    du = '{-(v[0] * v[1]), v[0] * v[0] + v[2] * v[2], -(v[1] * v[2])};
    okf = unit_vec(v, f);
    okr = unit_vec(dr, r);
    oku = unit_vec(du, u);
    res = '{r[0], r[1], r[2], u[0], u[1], u[2], f[0], f[1], f[2], !(okf && okr && oku)};
    return res;
  endfunction

  task automatic report(input string what, input logic [15:0] got, want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  // Check each result against the oldest prediction.
  always @(posedge clk) begin
    rot_t want;
    logic [15:0] g[9], w[9];
    if (!rst && m_tvalid && m_tready) begin
      if (pending_rot.size() == 0) begin
        report("unexpected result", 16'd0, 16'd0);
      end else begin
        want = pending_rot.pop_front();
        g = {>>{m_tdata}};
        w = '{want.fz, want.fy, want.fx, want.uz, want.uy, want.ux, want.rz, want.ry, want.rx};
        for (int i = 0; i < 9; i++)
          if (g[i] !== w[i]) report($sformatf("component %0d", 8 - i), g[i], w[i]);
        if (m_tuser[0] !== want.degen)
          report("degenerate", 16'(m_tuser), 16'(want.degen));
      end
    end
  end

  // Receiver stall pattern.
  always @(negedge clk) begin
    if (rst) m_tready <= 0;
    else m_tready <= !gap();
  end

  // Leaves s_tvalid high; the next send or drain decides it at this negedge.
  task automatic send_target(input logic [31:0] tx, ty, tz);
    while (gap()) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {tz, ty, tx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_rot.push_back(look_at(tx, ty, tz));
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (pending_rot.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_POS_X) cam_x = val;
    else if (idx == CFG_POS_Y) cam_y = val;
    else if (idx == CFG_POS_Z) cam_z = val;
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic set_camera(input logic [31:0] px, py, pz);
    drain();
    write_reg(CFG_POS_X, px);
    write_reg(CFG_POS_Y, py);
    write_reg(CFG_POS_Z, pz);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(64)) - 32);
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      3: return $urandom_range(1) ? 32'h7FFF_FFF0 + $urandom_range(15)
                                  : 32'h8000_0000 + $urandom_range(15);
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  task automatic test_directed();
    send_target(0, 0, 0);                      // target on the camera
    send_target(0, 32'h0001_0000, 0);          // straight up
    send_target(0, 32'hFFFF_0000, 0);          // straight down
    send_target(32'h0001_0000, 0, 0);
    send_target(0, 0, 32'h0001_0000);
    send_target(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_target(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_target(32'h7FFF_FFFF, 32'h8000_0000, 1);
    send_target(1, 0, 1);
    send_target(32'hFFFF_FFFF, 5, 32'hFFFF_FFFF);
    send_target(3, 32'h7FFF_FFFF, 0);           // tiny side terms truncated away
    send_target(7, 32'h8000_0000, 32'hFFFF_FFF9);
    send_target(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    set_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_target(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_target(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_target(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF);
    send_target(0, 0, 0);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 400 == 399) begin
        set_camera(rand_coord(), rand_coord(), rand_coord());
        write_reg(CFG_UNMAPPED, $urandom);      // unmapped index, ignored
      end
      if (i == 600) drain();                    // let the pipe run dry once
      idle_on = !(i >= 1000 && i < 1300);
      send_target(rand_coord(), rand_coord(), rand_coord());
    end
    idle_on = 1;
  endtask

  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    cfg_valid = 0;
    cfg_index = CFG_POS_X;
    cfg_data = '0;
    m_tready = 0;
    cam_x = 0;
    cam_y = 0;
    cam_z = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    set_camera(0, 0, 0);
    test_random(2000);
    drain();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
